// ----- hdl/grm_pkg.sv -----
package grm_pkg;

  // map geometry
  localparam int MapSize  = 16;
  localparam int MapIdxW  = $clog2(MapSize);
  localparam int QLim     = MapSize * 5;     // cell q/5 leaves the map at q >= QLim

  // stream widths
  localparam int InDataW  = 88;
  localparam int OutDataW = 48;

  // configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 21;
  localparam logic [CfgIdxW-1:0] CFG_SCREEN_ROWS    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_STEPS      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_EDGE_COS_LIMIT = 2'd2;

  localparam logic [7:0]  RowsReset  = 8'd43;
  localparam logic [9:0]  StepsReset = 10'd230;
  localparam logic [20:0] CosReset   = 21'd1048560;

  // item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_CAST = 1'b1;

  // datapath widths
  localparam int NumW  = 27;   // pos*40 + dir*n
  localparam int CellW = 11;
  localparam int VW    = 21;   // corner vector, Q12
  localparam int DW    = 42;   // squared distance
  localparam int DotW  = 38;
  localparam int MulW  = 42;   // serial multiplier operand width
  localparam int ProdW = 2 * MulW;
  localparam int DivW  = 18;   // wall_top dividend magnitude
  localparam int DenW  = 11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MARCH,
    ST_CORNER,
    ST_DOT,
    ST_MUL1_LD,
    ST_MUL1_RUN,
    ST_MUL2_LD,
    ST_MUL2_RUN,
    ST_CMP,
    ST_DIV_LD,
    ST_DIV_RUN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_row;
    logic cast_start;
    logic march;
    logic corner;
    logic dot;
    logic mul_ld_sq;
    logic mul_ld_lim;
    logic mul_run;
    logic cmp;
    logic div_ld;
    logic div_run;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic march_end;
    logic corner_last;
    logic mul_done;
    logic cmp_last;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/grm_ctrl.sv -----
module grm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  logic           in_mode,
  output logic           in_tready,
  input  grm_pkg::stat_t stat,
  output grm_pkg::cmd_t  cmd
);
  import grm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid && in_mode == MODE_CAST) state_nxt = ST_MARCH;
      ST_MARCH:    if (stat.march_end) state_nxt = ST_CORNER;
      ST_CORNER:   if (stat.corner_last) state_nxt = ST_DOT;
      ST_DOT:      state_nxt = ST_MUL1_LD;
      ST_MUL1_LD:  state_nxt = ST_MUL1_RUN;
      ST_MUL1_RUN: if (stat.mul_done) state_nxt = ST_MUL2_LD;
      ST_MUL2_LD:  state_nxt = ST_MUL2_RUN;
      ST_MUL2_RUN: if (stat.mul_done) state_nxt = ST_CMP;
      ST_CMP:      state_nxt = stat.cmp_last ? ST_DIV_LD : ST_DOT;
      ST_DIV_LD:   state_nxt = ST_DIV_RUN;
      ST_DIV_RUN:  if (stat.div_done) state_nxt = ST_FIN;
      ST_FIN:      if (stat.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready      = 1'b1;
        cmd.load_row   = in_tvalid && in_mode == MODE_LOAD;
        cmd.cast_start = in_tvalid && in_mode == MODE_CAST;
      end
      ST_MARCH:    cmd.march      = 1'b1;
      ST_CORNER:   cmd.corner     = 1'b1;
      ST_DOT:      cmd.dot        = 1'b1;
      ST_MUL1_LD:  cmd.mul_ld_sq  = 1'b1;
      ST_MUL1_RUN: cmd.mul_run    = 1'b1;
      ST_MUL2_LD:  cmd.mul_ld_lim = 1'b1;
      ST_MUL2_RUN: cmd.mul_run    = 1'b1;
      ST_CMP:      cmd.cmp        = 1'b1;
      ST_DIV_LD:   cmd.div_ld     = 1'b1;
      ST_DIV_RUN:  cmd.div_run    = 1'b1;
      ST_FIN:      cmd.out_load   = stat.out_free;
      default:     cmd            = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded into a full output slot");
  a_march_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARCH && stat.march_end) |=> state_r == ST_CORNER)
    else $error("march end not followed by corner scan");
  a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL1_RUN && stat.mul_done) |=> state_r == ST_MUL2_LD)
    else $error("second product not started");
`endif

endmodule

// ----- hdl/grm_dp.sv -----
module grm_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  grm_pkg::cmd_t                    cmd,
  output grm_pkg::stat_t                   stat,
  input  logic [grm_pkg::InDataW-1:0]      in_tdata,
  input  logic                             cfg_wr_en,
  input  logic [grm_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [grm_pkg::CfgDataW-1:0]     cfg_wdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [grm_pkg::OutDataW-1:0]     out_tdata
);
  import grm_pkg::*;

  // input fields
  logic [3:0]         f_row_index;
  logic [15:0]        f_row_walls, f_pos_x, f_pos_y;
  logic signed [15:0] f_dir_x, f_dir_y;
  assign f_row_index = in_tdata[3:0];
  assign f_row_walls = in_tdata[19:4];
  assign f_pos_x     = in_tdata[35:20];
  assign f_pos_y     = in_tdata[51:36];
  assign f_dir_x     = $signed(in_tdata[67:52]);
  assign f_dir_y     = $signed(in_tdata[83:68]);

  // config and map
  logic [7:0]         rows_r;
  logic [9:0]         steps_r;
  logic [20:0]        cos_r;
  logic [MapSize-1:0] map_r [MapSize];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= RowsReset;
      steps_r <= StepsReset;
      cos_r   <= CosReset;
      for (int i = 0; i < MapSize; i++) map_r[i] <= '0;
    end else begin
      if (cfg_wr_en) begin
        priority case (cfg_index)
          CFG_SCREEN_ROWS:    rows_r  <= cfg_wdata[7:0];
          CFG_MAX_STEPS:      steps_r <= cfg_wdata[9:0];
          CFG_EDGE_COS_LIMIT: cos_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load_row && int'(f_row_index) < MapSize)
        map_r[f_row_index[MapIdxW-1:0]] <= MapSize'(f_row_walls);
    end
  end

  // ---------------- march ----------------
  logic [15:0]            px_r, py_r;
  logic signed [15:0]     dx_r, dy_r;
  logic signed [NumW-1:0] numx_r, numy_r;
  logic [9:0]             n_r, lim_r;
  logic signed [CellW-1:0] bx_r, by_r;
  logic                   hit_r;

  function automatic logic signed [CellW-1:0] cell_of(input logic signed [NumW-1:0] num);
    logic [11:0] qo;
    logic [23:0] pr;
    qo = 12'(num[NumW-1:15] + 12'sd1025);   // q + 5*205, floor(q/5) via reciprocal
    pr = qo * 12'd3277;
    return $signed({1'b0, pr[23:14]}) - CellW'(205);
  endfunction

  function automatic logic signed [NumW-1:0] start_num(input logic [15:0] p,
                                                       input logic signed [15:0] d);
    return $signed({5'b0, p, 5'b0}) + $signed({3'b0, p, 3'b0}) + NumW'(d);
  endfunction

  logic signed [11:0]      qx, qy;
  logic signed [CellW-1:0] cx, cy;
  logic                    in_map, wall, hit_now;
  assign qx      = numx_r[NumW-1:15];
  assign qy      = numy_r[NumW-1:15];
  assign cx      = cell_of(numx_r);
  assign cy      = cell_of(numy_r);
  assign in_map  = !qx[11] && !qy[11] && (int'(qx) < QLim) && (int'(qy) < QLim);
  assign wall    = map_r[cy[MapIdxW-1:0]][cx[MapIdxW-1:0]];
  assign hit_now = !in_map || wall;

  always_ff @(posedge clk) begin
    if (cmd.cast_start) begin
      px_r   <= f_pos_x;
      py_r   <= f_pos_y;
      dx_r   <= f_dir_x;
      dy_r   <= f_dir_y;
      numx_r <= start_num(f_pos_x, f_dir_x);
      numy_r <= start_num(f_pos_y, f_dir_y);
      n_r    <= 10'd1;
      lim_r  <= (steps_r == '0) ? 10'd1 : steps_r;
    end else if (cmd.march) begin
      if (hit_now || n_r == lim_r) begin
        bx_r  <= cx;
        by_r  <= cy;
        hit_r <= hit_now;
      end else begin
        numx_r <= numx_r + NumW'(dx_r);
        numy_r <= numy_r + NumW'(dy_r);
        n_r    <= n_r + 10'd1;
      end
    end
  end

  // ---------------- corners ----------------
  function automatic logic signed [VW-1:0] vec_of(input logic signed [CellW-1:0] c,
                                                  input logic k, input logic [15:0] p);
    logic signed [CellW-1:0] cc;
    logic signed [CellW+12:0] v;
    cc = c + CellW'(k);
    v  = $signed({cc, 12'b0}) - $signed({{(CellW-3){1'b0}}, p});
    return v[VW-1:0];
  endfunction

  logic [1:0]             k_r, first_r, second_r;
  logic                   sec_v_r, j_r;
  logic [DW-1:0]          d1_r, d2_r, corner_d2;
  logic [DW-1:0]          lim2_r;
  logic signed [VW-1:0]   kvx, kvy;
  logic signed [2*VW-1:0] sqx, sqy;

  assign kvx       = vec_of(bx_r, k_r[1], px_r);
  assign kvy       = vec_of(by_r, k_r[0], py_r);
  assign sqx       = kvx * kvx;
  assign sqy       = kvy * kvy;
  assign corner_d2 = $unsigned(sqx) + $unsigned(sqy);

  always_ff @(posedge clk) begin
    if (cmd.cast_start) begin
      k_r <= '0;
      j_r <= 1'b0;
    end else if (cmd.corner) begin
      k_r    <= k_r + 2'd1;
      lim2_r <= cos_r * cos_r;
      if (k_r == 2'd0) begin
        first_r <= k_r;
        d1_r    <= corner_d2;
        sec_v_r <= 1'b0;
      end else if (corner_d2 < d1_r) begin
        second_r <= first_r;
        d2_r     <= d1_r;
        first_r  <= k_r;
        d1_r     <= corner_d2;
        sec_v_r  <= 1'b1;
      end else if (!sec_v_r || corner_d2 < d2_r) begin
        second_r <= k_r;
        d2_r     <= corner_d2;
        sec_v_r  <= 1'b1;
      end
    end else if (cmd.cmp) begin
      j_r <= 1'b1;
    end
  end

  // ---------------- dot product and edge test ----------------
  logic [1:0]              jk;
  logic signed [VW-1:0]    jvx, jvy;
  logic signed [DotW-1:0]  dot;
  logic [MulW-1:0]         dot_mag_r, dd_r;
  logic                    ok_r, edge_r;

  assign jk  = j_r ? second_r : first_r;
  assign jvx = vec_of(bx_r, jk[1], px_r);
  assign jvy = vec_of(by_r, jk[0], py_r);
  assign dot = DotW'(dx_r * jvx) + DotW'(dy_r * jvy);

  // serial shift-add multiplier, one bit per cycle
  logic [MulW-1:0]       mul_a_r, mul_hi_r, mul_lo_r;
  logic [5:0]            mul_cnt_r;
  logic [MulW:0]         mul_sum;
  logic [ProdW-1:0]      prod, dot2_r;
  assign mul_sum = {1'b0, mul_hi_r} + (mul_lo_r[0] ? {1'b0, mul_a_r} : '0);
  assign prod    = {mul_hi_r, mul_lo_r};

  always_ff @(posedge clk) begin
    if (cmd.cast_start) edge_r <= 1'b0;
    if (cmd.dot) begin
      ok_r      <= (j_r ? d2_r : d1_r) != '0 && dot > 0;
      dot_mag_r <= MulW'(dot[DotW-2:0]);
      dd_r      <= j_r ? d2_r : d1_r;
    end
    if (cmd.mul_ld_sq) begin
      mul_a_r   <= dot_mag_r;
      mul_hi_r  <= '0;
      mul_lo_r  <= dot_mag_r;
      mul_cnt_r <= '0;
    end else if (cmd.mul_ld_lim) begin
      dot2_r    <= prod;
      mul_a_r   <= lim2_r;
      mul_hi_r  <= '0;
      mul_lo_r  <= dd_r;
      mul_cnt_r <= '0;
    end else if (cmd.mul_run) begin
      mul_hi_r  <= mul_sum[MulW:1];
      mul_lo_r  <= {mul_sum[0], mul_lo_r[MulW-1:1]};
      mul_cnt_r <= mul_cnt_r + 6'd1;
    end
    if (cmd.cmp && ok_r && {dot2_r[ProdW-13:0], 12'b0} > prod) edge_r <= 1'b1;
  end

  // ---------------- wall_top divider ----------------
  logic signed [10:0]   nm20;
  logic signed [19:0]   top_num;
  logic [DivW-1:0]      dq_r;
  logic [DenW-1:0]      rem_r, den_r;
  logic [4:0]           div_cnt_r;
  logic                 neg_r;
  logic [DenW:0]        shifted;
  logic                 ge;
  logic signed [12:0]   top;

  assign nm20    = $signed({1'b0, n_r}) - 11'sd20;
  assign top_num = $signed({1'b0, rows_r}) * nm20;
  assign shifted = {rem_r, dq_r[DivW-1]};
  assign ge      = shifted >= {1'b0, den_r};
  assign top     = neg_r ? -$signed({1'b0, dq_r[11:0]}) : $signed({1'b0, dq_r[11:0]});

  always_ff @(posedge clk) begin
    if (cmd.div_ld) begin
      neg_r     <= top_num[19];
      dq_r      <= top_num[19] ? DivW'(-top_num) : DivW'(top_num);
      rem_r     <= '0;
      den_r     <= {n_r, 1'b0};
      div_cnt_r <= '0;
    end else if (cmd.div_run) begin
      rem_r     <= ge ? DenW'(shifted - {1'b0, den_r}) : shifted[DenW-1:0];
      dq_r      <= {dq_r[DivW-2:0], ge};
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end

  // ---------------- shade and output slot ----------------
  logic [2:0]  shade;
  logic [11:0] n4, n3;
  logic [10:0] n2;
  assign n4 = {n_r, 2'b0};
  assign n3 = {2'b0, n_r} + {1'b0, n_r, 1'b0};
  assign n2 = {n_r, 1'b0};

  always_comb begin
    priority if (n4 < {2'b0, lim_r}) shade = 3'd0;
    else if (n3 < {2'b0, lim_r})     shade = 3'd1;
    else if (n2 < {1'b0, lim_r})     shade = 3'd2;
    else if (n_r < lim_r)            shade = 3'd3;
    else                             shade = 3'd4;
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata <= {7'b0, shade, edge_r,
                    13'($signed({5'b0, rows_r}) - top), top, !hit_r, n_r};
    end
  end

  assign out_tvalid       = out_valid_r;
  assign stat.march_end   = hit_now || n_r == lim_r;
  assign stat.corner_last = k_r == 2'd3;
  assign stat.mul_done    = int'(mul_cnt_r) == MulW - 1;
  assign stat.cmp_last    = j_r;
  assign stat.div_done    = int'(div_cnt_r) == DivW - 1;
  assign stat.out_free    = !out_valid_r || out_tready;

`ifndef NO_ASSERTIONS
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.march |-> (n_r <= lim_r && n_r != '0))
    else $error("march count outside limit");
`endif

endmodule

// ----- hdl/grid_ray_march_column.sv -----
// Fixed-step grid ray caster for one screen column. A load beat (tuser 0) writes one row
// of the 16x16 wall map and gives no result; a cast beat (tuser 1) marches the ray one
// tenth-unit step per cycle and returns one result beat. The step count n is at most
// max_steps (or 1 when max_steps is 0). The march loop probes one map cell a cycle, the
// four cell corners are then ranked, then a bit-serial 42-bit multiplier runs twice for
// each of the two nearest corners, then a bit-serial divider with an 18-bit dividend
// forms wall_top. A load beat leaves the block idle. The block accepts a new beat the
// cycle after a result is loaded, also while that result waits on the output register;
// a cast that finishes while the register is still full waits there until it drains.
// Configuration writes are taken any cycle but belong to idle time.
module grid_ray_march_column (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: row_index[3:0], row_walls[19:4], pos_x[35:20], pos_y[51:36],
  //           dir_x[67:52], dir_y[83:68], zero pad
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [grm_pkg::InDataW-1:0]   in_tdata,
  input  logic                          in_tuser,   // mode
  // out_tdata: hit_steps[9:0], reached_limit[10], wall_top[23:11], wall_bottom[36:24],
  //            edge_hit[37], shade[40:38], zero pad
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [grm_pkg::OutDataW-1:0]  out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [grm_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [grm_pkg::CfgDataW-1:0]  cfg_wdata
);
  import grm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: one step of the cast per state
  grm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // map, march, corner test, divider and output slot
  grm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
